// ===== rtl/irpd_pkg.sv =====
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types and constants for the infrared remote pulse decoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

   // Field widths
   localparam int TIME_W  = 16;
   localparam int COUNT_W = 6;
   localparam int BYTE_W  = 8;

   // Request opcodes
   localparam logic [1:0] OP_EDGE  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_REARM = 2'd2;

   // Threshold reset value in timer ticks
   localparam logic [TIME_W-1:0] THRESHOLD_RESET = 16'd3000;

   // Pulse count saturation point
   localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

   // Pulse numbers that bound each data byte
   localparam logic [COUNT_W-1:0] ADDR_FIRST     = 6'd2;
   localparam logic [COUNT_W-1:0] ADDR_INV_FIRST = 6'd10;
   localparam logic [COUNT_W-1:0] CMD_FIRST      = 6'd18;
   localparam logic [COUNT_W-1:0] CMD_INV_FIRST  = 6'd26;
   localparam logic [COUNT_W-1:0] DATA_END       = 6'd34;

   // One response
   typedef struct packed {
      logic              frame_ready;
      logic [BYTE_W-1:0] address_byte;
      logic [BYTE_W-1:0] address_inverse;
      logic [BYTE_W-1:0] cmd_byte;
      logic [BYTE_W-1:0] cmd_inverse;
   } result_type;

endpackage

// ===== rtl/ir_remote_pulse_decoder.sv =====
// ----------------------------------------------------------------------------
// ir_remote_pulse_decoder
// NEC-style infrared remote frame decoder fed by timestamped edge requests.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle: every request is decoded and
// applied to the capture state in the cycle it is accepted, and a frame read
// places its response in a two-entry output buffer. req_stall rises only when
// both buffer slots hold responses not yet taken, so throughput is one request
// per cycle while the response side keeps up. A read's response is written
// into the buffer and shown on the rsp_ ports once it heads the buffer. Edge
// and re-arm requests give no response. Write csr_write_data while the block
// is idle to change the one-bit width threshold (reset value 3000 ticks).
module ir_remote_pulse_decoder
   import irpd_pkg::*;
#(
   parameter int FRAME_PULSES = 36
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_opcode,
   input  logic              req_edge_rising,
   input  logic [TIME_W-1:0] req_timestamp,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_frame_ready,
   output logic [BYTE_W-1:0] rsp_address_byte,
   output logic [BYTE_W-1:0] rsp_address_inverse,
   output logic [BYTE_W-1:0] rsp_cmd_byte,
   output logic [BYTE_W-1:0] rsp_cmd_inverse,
   input  logic              csr_write_en,
   input  logic [TIME_W-1:0] csr_write_data
);

   logic       req_accept;
   logic       buf_full;
   logic       core_push;
   result_type core_data;
   result_type out_data;

   assign req_stall  = buf_full;
   assign req_accept = req_valid && !req_stall;

   // Decoder state
   irpd_core #(
      .FRAME_PULSES (FRAME_PULSES)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .req_accept      (req_accept),
      .req_opcode      (req_opcode),
      .req_edge_rising (req_edge_rising),
      .req_timestamp   (req_timestamp),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .rsp_push        (core_push),
      .rsp_data        (core_data)
   );

   // Response buffer
   irpd_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (core_push),
      .push_data (core_data),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (out_data)
   );

   assign rsp_frame_ready     = out_data.frame_ready;
   assign rsp_address_byte    = out_data.address_byte;
   assign rsp_address_inverse = out_data.address_inverse;
   assign rsp_cmd_byte        = out_data.cmd_byte;
   assign rsp_cmd_inverse     = out_data.cmd_inverse;

endmodule

// ===== rtl/irpd_core.sv =====
// ----------------------------------------------------------------------------
// irpd_core
// Capture state, pulse width measurement and byte shift registers. Updates
// on each accepted request and emits a response for frame reads.
// ----------------------------------------------------------------------------
module irpd_core
   import irpd_pkg::*;
#(
   parameter int FRAME_PULSES = 36
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_accept,
   input  logic [1:0]        req_opcode,
   input  logic              req_edge_rising,
   input  logic [TIME_W-1:0] req_timestamp,
   input  logic              csr_write_en,
   input  logic [TIME_W-1:0] csr_write_data,
   output logic              rsp_push,
   output result_type        rsp_data
);

   localparam logic [COUNT_W-1:0] FRAME_COUNT = COUNT_W'(FRAME_PULSES);

   logic [TIME_W-1:0]  threshold_ff,   threshold_in;
   logic               start_valid_ff, start_valid_in;
   logic [TIME_W-1:0]  start_time_ff,  start_time_in;
   logic [COUNT_W-1:0] count_ff,       count_in;
   logic               capture_ff,     capture_in;
   logic [BYTE_W-1:0]  addr_ff,        addr_in;
   logic [BYTE_W-1:0]  addr_inv_ff,    addr_inv_in;
   logic [BYTE_W-1:0]  cmd_ff,         cmd_in;
   logic [BYTE_W-1:0]  cmd_inv_ff,     cmd_inv_in;

   logic [TIME_W-1:0]  pulse_width;
   logic               pulse_bit;
   logic [COUNT_W-1:0] count_inc;

   // Pulse width (wraps with the timer) and bit decision
   assign pulse_width = req_timestamp - start_time_ff;
   assign pulse_bit   = pulse_width > threshold_ff;
   assign count_inc   = count_ff + 1'b1;

   // Threshold register
   assign threshold_in = csr_write_en ? csr_write_data : threshold_ff;

   // Next state and response
   always_comb begin
      start_valid_in = start_valid_ff;
      start_time_in  = start_time_ff;
      count_in       = count_ff;
      capture_in     = capture_ff;
      addr_in        = addr_ff;
      addr_inv_in    = addr_inv_ff;
      cmd_in         = cmd_ff;
      cmd_inv_in     = cmd_inv_ff;
      rsp_push       = 1'b0;
      rsp_data       = '0;

      if (req_accept) begin
         case (req_opcode)
            OP_EDGE: begin
               if (capture_ff) begin
                  if (!start_valid_ff) begin
                     if (req_edge_rising) begin
                        start_time_in  = req_timestamp;
                        start_valid_in = 1'b1;
                     end
                  end else if (!req_edge_rising) begin
                     // falling edge closes the pulse
                     if (count_ff inside {[ADDR_FIRST:ADDR_INV_FIRST-6'd1]}) begin
                        addr_in = {addr_ff[BYTE_W-2:0], pulse_bit};
                     end else if (count_ff inside {[ADDR_INV_FIRST:CMD_FIRST-6'd1]}) begin
                        addr_inv_in = {addr_inv_ff[BYTE_W-2:0], pulse_bit};
                     end else if (count_ff inside {[CMD_FIRST:CMD_INV_FIRST-6'd1]}) begin
                        cmd_in = {cmd_ff[BYTE_W-2:0], pulse_bit};
                     end else if (count_ff inside {[CMD_INV_FIRST:DATA_END-6'd1]}) begin
                        cmd_inv_in = {cmd_inv_ff[BYTE_W-2:0], pulse_bit};
                     end
                     if (count_ff != COUNT_MAX) begin
                        count_in = count_inc;
                        if (count_inc == FRAME_COUNT) begin
                           capture_in = 1'b0;
                        end
                     end
                     start_valid_in = 1'b0;
                  end
               end
            end
            OP_READ: begin
               rsp_push = 1'b1;
               if (count_ff >= FRAME_COUNT) begin
                  rsp_data.frame_ready     = 1'b1;
                  rsp_data.address_byte    = addr_ff;
                  rsp_data.address_inverse = addr_inv_ff;
                  rsp_data.cmd_byte        = cmd_ff;
                  rsp_data.cmd_inverse     = cmd_inv_ff;
                  capture_in  = 1'b1;
                  count_in    = '0;
                  addr_in     = '0;
                  addr_inv_in = '0;
                  cmd_in      = '0;
                  cmd_inv_in  = '0;
               end
            end
            OP_REARM: begin
               start_valid_in = 1'b0;
               capture_in     = 1'b1;
            end
            default: begin
               // unused opcode: no effect
            end
         endcase
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= THRESHOLD_RESET;
         start_valid_ff <= 1'b0;
         start_time_ff  <= '0;
         count_ff       <= '0;
         capture_ff     <= 1'b1;
         addr_ff        <= '0;
         addr_inv_ff    <= '0;
         cmd_ff         <= '0;
         cmd_inv_ff     <= '0;
      end else begin
         threshold_ff   <= threshold_in;
         start_valid_ff <= start_valid_in;
         start_time_ff  <= start_time_in;
         count_ff       <= count_in;
         capture_ff     <= capture_in;
         addr_ff        <= addr_in;
         addr_inv_ff    <= addr_inv_in;
         cmd_ff         <= cmd_in;
         cmd_inv_ff     <= cmd_inv_in;
      end
   end

`ifndef NO_ASSERTIONS
   // capture only shuts off when the frame count is reached
   a_capture_stop: assert property (@(posedge clock) disable iff (reset)
      $fell(capture_ff) |-> count_ff == FRAME_COUNT)
      else $error("capture stopped away from frame end");

   // a complete read clears the count
   a_read_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_opcode == OP_READ && count_ff >= FRAME_COUNT)
      |=> count_ff == '0 && capture_ff)
      else $error("complete read did not clear the frame");

   // an incomplete read returns all-zero bytes
   a_empty_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && !rsp_data.frame_ready) |-> rsp_data == '0)
      else $error("incomplete read returned data");
`endif

endmodule

// ===== rtl/irpd_rsp_buf.sv =====
// ----------------------------------------------------------------------------
// irpd_rsp_buf
// Two-entry response buffer that separates the decoder from the response
// stall, so requests keep flowing while a response waits.
// ----------------------------------------------------------------------------
module irpd_rsp_buf
   import irpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_data
);

   logic [1:0] count_ff,  count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   result_type slot_ff [2];
   logic       pop;

   assign full      = count_ff == 2'd2;
   assign rsp_valid = count_ff != 2'd0;
   assign rsp_data  = slot_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Response slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("response pushed into full buffer");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      (push && count_ff == 2'd0) |=> rsp_valid)
      else $error("pushed response not presented");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1 && pop && !push) |=> !rsp_valid)
      else $error("buffer not empty after last response taken");
`endif

endmodule
